### rtl/sensor_minmax_calibrate_normalize_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor min/max calibrate and normalize block
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MINMAX_CALIBRATE_NORMALIZE_MACROS_SVH
`define SENSOR_MINMAX_CALIBRATE_NORMALIZE_MACROS_SVH

// Same-cycle implication.
`define SMCN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("smcn assertion failed");

// Next-cycle implication.
`define SMCN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("smcn assertion failed");

`endif

### rtl/smcn_pkg.sv
// ----------------------------------------------------------------------------
// smcn_pkg
// Shared constants, mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smcn_pkg;

    localparam int DEF_CHANNELS  = 8;
    localparam int DEF_BATCH_LEN = 10;

    localparam int MODE_W   = 2;
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 10;
    localparam int CNT_W    = 4;
    localparam int QUO_W    = 10;
    localparam int PROD_W   = SAMPLE_W + QUO_W;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam int unsigned FULL_SCALE     = 1000;
    localparam int unsigned INIT_MIN_RESET = 2500;

    localparam logic [MODE_W-1:0] MODE_NORMALIZE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CALIBRATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;

    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic prep;      // read calibration, load divider
        logic div_step;  // retire one quotient bit
        logic update;    // apply calibrate or clear
        logic load_out;  // move result into output register
    } cmd_t;

    typedef struct packed {
        logic is_norm;   // normalize on a valid channel
        logic out_free;  // output register can take a result
    } sts_t;

endpackage

### rtl/sensor_minmax_calibrate_normalize.sv
// ----------------------------------------------------------------------------
// sensor_minmax_calibrate_normalize
// Min/max calibration and 0..1000 normalization of reflectance channels.
// ----------------------------------------------------------------------------
// Every accepted transaction yields one result. Calibrate and clear
// transactions pass through the decode and finish states from acceptance
// to the next ready; normalize transactions also run the restoring
// divider, which retires one quotient bit per cycle over 10 steps between
// decode and finish. A result held in the output register does not
// block the next transaction unless a second result is ready before the
// first is taken. A new initial_minimum applies at the next clear.
`include "sensor_minmax_calibrate_normalize_macros.svh"

module sensor_minmax_calibrate_normalize #(
    parameter int CHANNELS  = smcn_pkg::DEF_CHANNELS,
    parameter int BATCH_LEN = smcn_pkg::DEF_BATCH_LEN
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [smcn_pkg::SAMPLE_W-1:0]  cfg_wdata,   // initial_minimum
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [smcn_pkg::S_TDATA_W-1:0] s_tdata,     // channel[2:0], sample[14:3]
    input  logic [smcn_pkg::MODE_W-1:0]    s_tuser,     // mode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [smcn_pkg::M_TDATA_W-1:0] m_tdata,     // out_channel[2:0], level[12:3]
    output logic                           m_tuser      // level_valid
);
    import smcn_pkg::*;

    cmd_t cmd;
    sts_t sts;

    smcn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smcn_dpath #(
        .CHANNELS  (CHANNELS),
        .BATCH_LEN (BATCH_LEN)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `SMCN_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `SMCN_ASSERT_IMP(a_level_range, m_tvalid, m_tdata[12:3] <= LEVEL_W'(FULL_SCALE))
    `SMCN_ASSERT_IMP(a_level_zero_when_invalid, m_tvalid && !m_tuser, m_tdata[12:3] == '0)

endmodule

### rtl/smcn_ctrl.sv
// ----------------------------------------------------------------------------
// smcn_ctrl
// Sequencer: accept, decode, divide (normalize only), then hand the result to the output.
// ----------------------------------------------------------------------------
module smcn_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  smcn_pkg::sts_t sts,
    output smcn_pkg::cmd_t cmd
);
    import smcn_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;
    localparam int STEP_W = $clog2(QUO_W);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.capture  = s_tvalid && s_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_norm) begin
                    cmd.prep   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    cmd.update = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register drains
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/smcn_dpath.sv
// ----------------------------------------------------------------------------
// smcn_dpath
// Per-channel calibration tables, batch tracking, restoring divider and
// output register.
// ----------------------------------------------------------------------------
module smcn_dpath #(
    parameter int CHANNELS  = smcn_pkg::DEF_CHANNELS,
    parameter int BATCH_LEN = smcn_pkg::DEF_BATCH_LEN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [smcn_pkg::SAMPLE_W-1:0]    cfg_wdata,
    input  logic [smcn_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [smcn_pkg::MODE_W-1:0]      s_tuser,
    input  smcn_pkg::cmd_t                   cmd,
    output smcn_pkg::sts_t                   sts,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [smcn_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);
    import smcn_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SAMPLE_W-1:0] init_min_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic [SAMPLE_W-1:0] cal_low_reg    [CHANNELS];
    logic [SAMPLE_W-1:0] cal_high_reg   [CHANNELS];
    logic [SAMPLE_W-1:0] batch_low_reg  [CHANNELS];
    logic [SAMPLE_W-1:0] batch_high_reg [CHANNELS];
    logic [CNT_W-1:0]    batch_cnt_reg  [CHANNELS];

    logic                zero_reg, full_reg;
    logic [SAMPLE_W-1:0] den_reg, rem_reg, rem_next;
    logic [QUO_W-1:0]    num_reg, quo_reg;

    logic                out_valid_reg, out_lvalid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [LEVEL_W-1:0]  out_level_reg, level_sel;

    logic                ch_ok, is_norm, is_cal, is_clear;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] cur_low, cur_high, b_low, b_high;
    logic [SAMPLE_W-1:0] new_blow, new_bhigh, diff, span;
    logic [CNT_W-1:0]    b_cnt, cnt_inc;
    logic                batch_done;
    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W:0]   trial;
    logic                ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_min_reg <= SAMPLE_W'(INIT_MIN_RESET);
        end else if (cfg_wen) begin
            init_min_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_tuser;
            ch_reg     <= s_tdata[CH_W-1:0];
            sample_reg <= s_tdata[CH_W +: SAMPLE_W];
        end
    end

    assign ch_ok    = int'(ch_reg) < CHANNELS;
    assign is_norm  = (mode_reg == MODE_NORMALIZE) && ch_ok;
    assign is_cal   = (mode_reg == MODE_CALIBRATE) && ch_ok;
    assign is_clear = (mode_reg == MODE_CLEAR);
    assign idx      = IDX_W'(ch_reg);

    assign cur_low  = cal_low_reg[idx];
    assign cur_high = cal_high_reg[idx];
    assign b_low    = batch_low_reg[idx];
    assign b_high   = batch_high_reg[idx];
    assign b_cnt    = batch_cnt_reg[idx];

    // first sample of a batch seeds both extremes
    assign new_blow   = (b_cnt == '0 || sample_reg < b_low)  ? sample_reg : b_low;
    assign new_bhigh  = (b_cnt == '0 || sample_reg > b_high) ? sample_reg : b_high;
    assign cnt_inc    = b_cnt + 1'b1;
    assign batch_done = cnt_inc >= CNT_W'(BATCH_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                cal_low_reg[c]   <= SAMPLE_W'(INIT_MIN_RESET);
                cal_high_reg[c]  <= '0;
                batch_cnt_reg[c] <= '0;
            end
        end else if (cmd.update && is_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                cal_low_reg[c]   <= init_min_reg;
                cal_high_reg[c]  <= '0;
                batch_cnt_reg[c] <= '0;
            end
        end else if (cmd.update && is_cal) begin
            if (batch_done) begin
                batch_cnt_reg[idx] <= '0;
                if (new_blow > cur_high) begin
                    cal_high_reg[idx] <= new_blow;
                end
                if (new_bhigh < cur_low) begin
                    cal_low_reg[idx] <= new_bhigh;
                end
            end else begin
                batch_cnt_reg[idx] <= cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && is_cal) begin
            batch_low_reg[idx]  <= new_blow;
            batch_high_reg[idx] <= new_bhigh;
        end
    end

    // Quotient is below 1024 whenever the sample lies inside the span, so
    // the upper product bits already sit below the divisor.
    assign diff    = sample_reg - cur_low;
    assign span    = cur_high - cur_low;
    assign product = PROD_W'(diff) * PROD_W'(FULL_SCALE);

    assign trial    = {rem_reg, num_reg[QUO_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? SAMPLE_W'(trial - {1'b0, den_reg}) : trial[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            zero_reg <= (cur_high <= cur_low) || (sample_reg <= cur_low);
            full_reg <= sample_reg >= cur_high;
            den_reg  <= span;
            rem_reg  <= product[PROD_W-1:QUO_W];
            num_reg  <= product[QUO_W-1:0];
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    always_comb begin
        if (!is_norm || zero_reg) begin
            level_sel = '0;
        end else if (full_reg) begin
            level_sel = LEVEL_W'(FULL_SCALE);
        end else begin
            level_sel = quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_ch_reg     <= ch_reg;
            out_level_reg  <= level_sel;
            out_lvalid_reg <= is_norm;
        end
    end

    assign sts.is_norm  = is_norm;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_level_reg, out_ch_reg});
    assign m_tuser  = out_lvalid_reg;

endmodule
